FILE: design/mfgr_pkg.sv
// Package for the monochrome framebuffer glyph renderer: display geometry,
// command and job types, queue status and the 6x8 glyph table.
// No dependencies.
`timescale 1ns / 1ps

package mfgr_pkg;

    // Display geometry
    localparam int DISPLAY_WIDTH  = 128;
    localparam int DISPLAY_HEIGHT = 64;
    localparam int PAGES          = (DISPLAY_HEIGHT + 7) / 8;
    localparam int STORE_DEPTH    = DISPLAY_WIDTH * PAGES;
    localparam int STORE_AW       = $clog2(STORE_DEPTH);

    // Glyph table
    localparam int         GLYPH_COLS  = 6;
    localparam int         GLYPH_COUNT = 5;
    localparam logic [7:0] FIRST_CODE  = 8'd32;
    localparam logic [7:0] ALL_WHITE   = 8'hFF;

    localparam logic [7:0] GLYPH_ROM [GLYPH_COUNT][GLYPH_COLS] = '{
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h5F, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h07, 8'h00, 8'h07, 8'h00, 8'h00},
        '{8'h14, 8'h7F, 8'h14, 8'h7F, 8'h14, 8'h00},
        '{8'h24, 8'h2A, 8'h7F, 8'h2A, 8'h12, 8'h00}
    };

    // Command queue between front and back (power of two)
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef enum logic [2:0] {
        CMD_SET_CURSOR = 3'd0,
        CMD_PUT_CHAR   = 3'd1,
        CMD_DRAW_PIXEL = 3'd2,
        CMD_FILL       = 3'd3,
        CMD_READ_BYTE  = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_CHAR,
        OP_PIXEL,
        OP_FILL,
        OP_READ
    } t_op;

    typedef enum logic [2:0] {
        BS_SWEEP,
        BS_IDLE,
        BS_READ,
        BS_MODIFY,
        BS_RESULT
    } t_bstate;

    // Classified request as the back end sees it
    typedef struct packed {
        t_op        op;
        logic [7:0] x;        // column, or glyph origin column
        logic [7:0] y;        // row, or glyph origin row
        logic [7:0] code;
        logic       color;
        logic [2:0] page;
        logic [7:0] rsp_col;  // cursor after the request
        logic [7:0] rsp_row;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // One glyph column; unknown codes are blank
    function automatic logic [7:0] glyph_col(input logic [7:0] code, input logic [2:0] col);
        logic [7:0] idx;
        logic [7:0] line;
        idx  = code - FIRST_CODE;
        line = 8'h00;
        if (code >= FIRST_CODE && idx < 8'(GLYPH_COUNT)) begin
            line = GLYPH_ROM[idx[2:0]][col];
        end
        return line;
    endfunction

endpackage

FILE: design/mfgr_if.sv
// Handshake channels of the glyph renderer: request in, response out.
// No dependencies.
`timescale 1ns / 1ps

interface mfgr_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic [7:0] char_code;
    logic       color;
    logic [2:0] page_sel;

    modport source (output valid, cmd, x_pos, y_pos, char_code, color, page_sel,
                    input ready);
    modport sink (input valid, cmd, x_pos, y_pos, char_code, color, page_sel,
                  output ready);
endinterface

interface mfgr_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [7:0] cursor_col;
    logic [7:0] cursor_row;

    modport source (output valid, read_data, cursor_col, cursor_row, input ready);
    modport sink (input valid, read_data, cursor_col, cursor_row, output ready);
endinterface

FILE: design/mfgr_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mfgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

FILE: design/mfgr_fifo.sv
// Short job queue between the front end and the back end.
// Depends on mfgr_pkg.
`timescale 1ns / 1ps

module mfgr_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mfgr_pkg::t_job   i_job,
    input  logic             i_pop,
    output mfgr_pkg::t_job   o_head,
    output mfgr_pkg::t_q_stat o_stat
);
    import mfgr_pkg::*;

    t_job            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr;
    logic [Q_AW-1:0] r_rptr;
    logic [Q_AW:0]   r_count;

    assign o_head       = r_mem[r_rptr];
    assign o_stat.full  = (r_count == (Q_AW + 1)'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + 1'b1;
            if (i_pop)  r_rptr <= r_rptr + 1'b1;
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

endmodule

FILE: design/mfgr_front.sv
// Front end: accepts requests, keeps the text cursor, classifies each request
// into a back-end job and pushes it to the queue. Depends on mfgr_pkg, mfgr_if.
`timescale 1ns / 1ps

module mfgr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mfgr_req_if.sink          i_req,
    input  logic              i_clearing,
    input  mfgr_pkg::t_q_stat i_q_stat,
    output logic              o_push,
    output mfgr_pkg::t_job    o_job
);
    import mfgr_pkg::*;

    logic [7:0] r_cur_x, r_cur_y;
    logic [7:0] n_cur_x, n_cur_y;
    logic       accept;

    assign i_req.ready = !i_q_stat.full && !i_clearing;
    assign accept      = i_req.valid && i_req.ready;
    assign o_push      = accept;

    // Classify the request and work out the cursor after it
    always_comb begin
        n_cur_x       = r_cur_x;
        n_cur_y       = r_cur_y;
        o_job.op      = OP_NOP;
        o_job.x       = i_req.x_pos;
        o_job.y       = i_req.y_pos;
        o_job.code    = i_req.char_code;
        o_job.color   = i_req.color;
        o_job.page    = i_req.page_sel;
        unique case (t_cmd'(i_req.cmd))
            CMD_SET_CURSOR: begin
                n_cur_x = i_req.x_pos;
                n_cur_y = i_req.y_pos;
            end
            CMD_PUT_CHAR: begin
                o_job.op = OP_CHAR;
                o_job.x  = r_cur_x;
                o_job.y  = r_cur_y;
                n_cur_x  = r_cur_x + 8'(GLYPH_COLS);
            end
            CMD_DRAW_PIXEL: begin
                // clipped pixels change nothing
                if ({1'b0, i_req.x_pos} < 9'(DISPLAY_WIDTH) &&
                    {1'b0, i_req.y_pos} < 9'(DISPLAY_HEIGHT)) begin
                    o_job.op = OP_PIXEL;
                end
            end
            CMD_FILL: begin
                o_job.op = OP_FILL;
            end
            CMD_READ_BYTE: begin
                // out-of-range reads return zero
                if ({1'b0, i_req.x_pos} < 9'(DISPLAY_WIDTH) &&
                    {1'b0, i_req.page_sel} < 4'(PAGES)) begin
                    o_job.op = OP_READ;
                end
            end
            default: ;
        endcase
        o_job.rsp_col = n_cur_x;
        o_job.rsp_row = n_cur_y;
    end

    // Cursor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x <= '0;
            r_cur_y <= '0;
        end else if (accept) begin
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
        end
    end

endmodule

FILE: design/mfgr_back.sv
// Back end: runs jobs against the frame store (read-modify-write per byte,
// store sweeps for fill and reset) and holds the response register.
// Depends on mfgr_pkg, mfgr_if, mfgr_ram.
`timescale 1ns / 1ps

module mfgr_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mfgr_pkg::t_job    i_head,
    input  mfgr_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    output logic              o_clearing,
    mfgr_rsp_if.source        o_rsp
);
    import mfgr_pkg::*;

    t_bstate             r_state, n_state;
    t_job                r_job;
    logic [2:0]          r_col;
    logic                r_half;
    logic [STORE_AW-1:0] r_sweep_addr;
    logic [7:0]          r_fill_byte;
    logic                r_sweep_rsp;
    logic [7:0]          r_rdata_cap;
    logic                r_out_valid;
    logic [7:0]          r_out_data, r_out_col, r_out_row;

    // Current byte step
    logic [STORE_AW-1:0] step_addr;
    logic [7:0]          step_mask, step_bits;
    logic                step_wok;
    logic                last_step, sweep_last, out_free, out_load;
    logic [7:0]          xc, line;
    logic [4:0]          q;
    logic [2:0]          off, j;
    logic [7:0]          row;

    // RAM port
    logic                ram_we;
    logic [STORE_AW-1:0] ram_addr;
    logic [7:0]          ram_wdata, ram_rdata;

    mfgr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign sweep_last = (r_sweep_addr == STORE_AW'(STORE_DEPTH - 1));
    assign last_step  = (r_job.op != OP_CHAR) || (r_col == 3'(GLYPH_COLS - 1) && r_half);
    assign out_free   = !r_out_valid || o_rsp.ready;

    // Address, mask and new bits of the byte under work
    always_comb begin
        xc        = r_job.x + 8'(r_col);
        q         = r_job.y[7:3] + 5'(r_half);
        off       = r_job.y[2:0];
        line      = glyph_col(r_job.code, r_col);
        step_addr = '0;
        step_mask = '0;
        step_bits = '0;
        step_wok  = 1'b0;
        j         = '0;
        row       = '0;
        case (r_job.op)
            OP_PIXEL: begin
                step_addr = STORE_AW'(r_job.x) +
                            STORE_AW'(r_job.y[7:3]) * STORE_AW'(DISPLAY_WIDTH);
                step_mask = 8'(1) << r_job.y[2:0];
                step_bits = {8{r_job.color}};
                step_wok  = 1'b1;
            end
            OP_CHAR: begin
                // lower half covers rows at or past the offset in the first page,
                // upper half the rows below the offset in the next page
                step_addr = STORE_AW'(xc) + STORE_AW'(q[2:0]) * STORE_AW'(DISPLAY_WIDTH);
                step_wok  = ({1'b0, xc} < 9'(DISPLAY_WIDTH)) && ({1'b0, q} < 6'(PAGES));
                for (int b = 0; b < 8; b++) begin
                    j   = 3'(b) - off;
                    row = {q, 3'(b)};
                    step_mask[b] = (r_half ? (3'(b) < off) : (3'(b) >= off)) &&
                                   ({1'b0, row} < 9'(DISPLAY_HEIGHT));
                    step_bits[b] = line[j] ? r_job.color : !r_job.color;
                end
            end
            OP_READ: begin
                step_addr = STORE_AW'(r_job.x) +
                            STORE_AW'(r_job.page) * STORE_AW'(DISPLAY_WIDTH);
            end
            default: ;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_SWEEP: begin
                if (sweep_last) n_state = r_sweep_rsp ? BS_RESULT : BS_IDLE;
            end
            BS_IDLE: begin
                if (!i_q_stat.empty) begin
                    case (i_head.op)
                        OP_NOP:  n_state = BS_RESULT;
                        OP_FILL: n_state = BS_SWEEP;
                        default: n_state = BS_READ;
                    endcase
                end
            end
            BS_READ:   n_state = BS_MODIFY;
            BS_MODIFY: n_state = last_step ? BS_RESULT : BS_READ;
            BS_RESULT: begin
                if (out_free) n_state = BS_IDLE;
            end
            default:   n_state = BS_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_pop      = 1'b0;
        o_clearing = 1'b0;
        out_load   = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = step_addr;
        ram_wdata  = (ram_rdata & ~step_mask) | (step_bits & step_mask);
        unique case (r_state)
            BS_SWEEP: begin
                ram_we     = 1'b1;
                ram_addr   = r_sweep_addr;
                ram_wdata  = r_fill_byte;
                o_clearing = !r_sweep_rsp;
            end
            BS_IDLE:   o_pop = !i_q_stat.empty;
            BS_READ:   ;
            BS_MODIFY: ram_we = step_wok;
            BS_RESULT: out_load = out_free;
            default:   ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BS_SWEEP;
            r_sweep_addr <= '0;
            r_fill_byte  <= '0;
            r_sweep_rsp  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BS_SWEEP) begin
                r_sweep_addr <= r_sweep_addr + 1'b1;
            end
            if (o_pop && i_head.op == OP_FILL) begin
                r_sweep_addr <= '0;
                r_fill_byte  <= i_head.color ? ALL_WHITE : 8'h00;
                r_sweep_rsp  <= 1'b1;
            end
            if (out_load)         r_out_valid <= 1'b1;
            else if (o_rsp.ready) r_out_valid <= 1'b0;
        end
    end

    // Job and step registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job       <= i_head;
            r_col       <= '0;
            r_half      <= 1'b0;
            r_rdata_cap <= '0;
        end else if (r_state == BS_MODIFY) begin
            if (r_job.op == OP_READ) r_rdata_cap <= ram_rdata;
            r_half <= !r_half;
            if (r_half) r_col <= r_col + 1'b1;
        end
    end

    // Response register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= r_rdata_cap;
            r_out_col  <= r_job.rsp_col;
            r_out_row  <= r_job.rsp_row;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.read_data  = r_out_data;
    assign o_rsp.cursor_col = r_out_col;
    assign o_rsp.cursor_row = r_out_row;

endmodule

FILE: design/mono_framebuffer_glyph_renderer.sv
// Write character does 12 byte read-modify-writes on the single store port;
// fill sweeps the whole store, one store byte per cycle.
// Throughput: one request at a time in the back end; a 2-entry queue lets
// the front take requests meanwhile. Reset: synchronous, active low; after it
// a sweep clears the whole store (1024 bytes) while i_req.ready is low.
`timescale 1ns / 1ps

module mono_framebuffer_glyph_renderer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mfgr_req_if.sink  i_req,
    mfgr_rsp_if.source o_rsp
);
    import mfgr_pkg::*;

    logic    w_push, w_pop, w_clearing;
    t_job    w_job, w_head;
    t_q_stat w_q_stat;

    mfgr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_clearing (w_clearing),
        .i_q_stat   (w_q_stat),
        .o_push     (w_push),
        .o_job      (w_job)
    );

    mfgr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    mfgr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_q_stat   (w_q_stat),
        .o_pop      (w_pop),
        .o_clearing (w_clearing),
        .o_rsp      (o_rsp)
    );

    // No request taken while the store is being cleared
    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !(i_req.valid && i_req.ready))
        else $error("request accepted during clearing sweep");

    // Queue is never pushed when full nor popped when empty
    a_queue_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_q_stat.full) && !(w_pop && w_q_stat.empty))
        else $error("job queue overflow or underflow");

    // Clearing sweep starts right after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        (i_rst_n && !$past(i_rst_n)) |-> w_clearing)
        else $error("no clearing sweep after reset");

    // Queue status is consistent
    a_queue_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_stat.full && w_q_stat.empty))
        else $error("queue both full and empty");

endmodule

FILE: verif/mono_framebuffer_glyph_renderer_tb.sv
// Self-checking testbench for mono_framebuffer_glyph_renderer: directed and random
// requests, a framebuffer scoreboard that predicts each response, random stalls.
// Depends on design/mfgr_pkg.sv, design/mfgr_if.sv and the renderer RTL.
`timescale 1ns / 1ps

// Display geometry and font as the scoreboard sees them
localparam int WIDTH_PX    = 128;
localparam int HEIGHT_PX   = 64;
localparam int PAGE_CNT    = (HEIGHT_PX + 7) / 8;
localparam int FRAME_BYTES = WIDTH_PX * PAGE_CNT;
localparam int GLYPH_W     = 6;
localparam int NUM_GLYPHS  = 5;
localparam int FIRST_GLYPH = 32;

localparam logic [7:0] FONT_6X8 [NUM_GLYPHS][GLYPH_W] = '{
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h5F, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h07, 8'h00, 8'h07, 8'h00, 8'h00},
    '{8'h14, 8'h7F, 8'h14, 8'h7F, 8'h14, 8'h00},
    '{8'h24, 8'h2A, 8'h7F, 8'h2A, 8'h12, 8'h00}
};

// Command codes the block ignores
localparam logic [2:0] CMD_RSVD_A = 3'd5;
localparam logic [2:0] CMD_RSVD_B = 3'd6;
localparam logic [2:0] CMD_RSVD_C = 3'd7;

typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic [7:0] char_code;
    logic       color;
    logic [2:0] page_sel;
} t_draw_req;

typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] cursor_col;
    logic [7:0] cursor_row;
} t_draw_rsp;

// Framebuffer and cursor mirror plus the queue of responses still due
class frame_scoreboard;
    logic [7:0] frame [FRAME_BYTES];
    logic [7:0] cur_col;
    logic [7:0] cur_row;
    t_draw_rsp  rsp_due [$];
    int         errors;

    function new();
        foreach (frame[k]) frame[k] = 8'h00;
        cur_col = 8'h00;
        cur_row = 8'h00;
        errors  = 0;
    endfunction

    function int pending();
        return rsp_due.size();
    endfunction

    // Single pixel, clipped to the visible area
    function void plot(input logic [7:0] x, input logic [7:0] y, input logic white);
        int unsigned addr;
        if (x >= WIDTH_PX || y >= HEIGHT_PX) return;
        addr = x + (y >> 3) * WIDTH_PX;
        if (white) frame[addr] = frame[addr] | (8'h01 << y[2:0]);
        else       frame[addr] = frame[addr] & ~(8'h01 << y[2:0]);
    endfunction

    function void note_request(input t_draw_req rq);
        t_draw_rsp  due;
        logic [7:0] line;
        due = '0;
        case (rq.cmd)
            mfgr_pkg::CMD_SET_CURSOR: begin
                cur_col = rq.x_pos;
                cur_row = rq.y_pos;
            end
            mfgr_pkg::CMD_PUT_CHAR: begin
                // glyph bits take the color, blank bits the inverse; unknown codes are blank
                for (int i = 0; i < GLYPH_W; i++) begin
                    line = 8'h00;
                    if (rq.char_code >= FIRST_GLYPH && rq.char_code < FIRST_GLYPH + NUM_GLYPHS)
                        line = FONT_6X8[int'(rq.char_code) - FIRST_GLYPH][i];
                    for (int j = 0; j < 8; j++)
                        plot(8'(cur_col + i), 8'(cur_row + j), line[j] ? rq.color : ~rq.color);
                end
                cur_col = 8'(cur_col + GLYPH_W);
            end
            mfgr_pkg::CMD_DRAW_PIXEL: plot(rq.x_pos, rq.y_pos, rq.color);
            mfgr_pkg::CMD_FILL: begin
                foreach (frame[k]) frame[k] = rq.color ? 8'hFF : 8'h00;
            end
            mfgr_pkg::CMD_READ_BYTE: begin
                if (rq.x_pos < WIDTH_PX && rq.page_sel < PAGE_CNT)
                    due.read_data = frame[rq.x_pos + rq.page_sel * WIDTH_PX];
            end
            default: ;
        endcase
        due.cursor_col = cur_col;
        due.cursor_row = cur_row;
        rsp_due.push_back(due);
    endfunction

    function void check_response(input t_draw_rsp got);
        t_draw_rsp due;
        if (rsp_due.size() == 0) begin
            $error("response with none due: read_data %0h cursor %0d,%0d",
                   got.read_data, got.cursor_col, got.cursor_row);
            errors++;
            return;
        end
        due = rsp_due.pop_front();
        if (got.read_data !== due.read_data) begin
            $error("read_data: expected %0h, got %0h", due.read_data, got.read_data);
            errors++;
        end
        if (got.cursor_col !== due.cursor_col) begin
            $error("cursor_col: expected %0d, got %0d", due.cursor_col, got.cursor_col);
            errors++;
        end
        if (got.cursor_row !== due.cursor_row) begin
            $error("cursor_row: expected %0d, got %0d", due.cursor_row, got.cursor_row);
            errors++;
        end
    endfunction
endclass

module mono_framebuffer_glyph_renderer_tb;

    localparam int RANDOM_REQS = 600;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 1100;    // longer than a fill
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;

    mfgr_req_if req_if ();
    mfgr_rsp_if rsp_if ();

    mono_framebuffer_glyph_renderer i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    frame_scoreboard sb;
    int              tx_idle_pct;
    int              rx_idle_pct;
    bit              hold_req;
    int unsigned     cycle_cnt;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Offer one request, idling at random first; valid stays up after acceptance
    task automatic send(input logic [2:0] cmd, input logic [7:0] x, input logic [7:0] y,
                        input logic [7:0] code, input logic color, input logic [2:0] page);
        while (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.cmd       <= cmd;
        req_if.x_pos     <= x;
        req_if.y_pos     <= y;
        req_if.char_code <= code;
        req_if.color     <= color;
        req_if.page_sel  <= page;
        @(posedge clk);
        while (!(req_if.valid && req_if.ready)) @(posedge clk);
    endtask

    // Mostly text runs and reads around the cursor; some clipped and ignored requests
    task automatic send_random();
        int         pick;
        logic [2:0] cmd;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] code;
        logic [2:0] page;
        pick = $urandom_range(0, 99);
        x    = 8'($urandom);
        y    = 8'($urandom);
        code = 8'($urandom);
        page = 3'($urandom);
        if (pick < 12) begin
            cmd = mfgr_pkg::CMD_SET_CURSOR;
            if ($urandom_range(0, 99) < 80) begin
                x = 8'($urandom_range(0, 130));
                y = 8'($urandom_range(0, 70));
            end
        end else if (pick < 46) begin
            cmd = mfgr_pkg::CMD_PUT_CHAR;
            if ($urandom_range(0, 99) < 70) code = 8'($urandom_range(32, 36));
        end else if (pick < 60) begin
            cmd = mfgr_pkg::CMD_DRAW_PIXEL;
            if ($urandom_range(0, 99) < 85) begin
                x = 8'($urandom_range(0, 135));
                y = 8'($urandom_range(0, 70));
            end
        end else if (pick < 62) begin
            cmd = mfgr_pkg::CMD_FILL;
        end else if (pick < 95) begin
            cmd = mfgr_pkg::CMD_READ_BYTE;
            // aim at the bytes the last glyphs touched
            if ($urandom_range(0, 99) < 70) begin
                x    = 8'(sb.cur_col - $urandom_range(0, 14));
                page = 3'((sb.cur_row + $urandom_range(0, 7)) >> 3);
            end
        end else begin
            cmd = 3'(CMD_RSVD_A + $urandom_range(0, 2));
        end
        send(cmd, x, y, code, 1'($urandom), page);
    endtask

    // Accepted requests and responses, sampled at the edge
    always @(posedge clk) begin : monitor
        t_draw_req rq;
        t_draw_rsp rs;
        if (rst_n && req_if.valid && req_if.ready) begin
            rq = '{req_if.cmd, req_if.x_pos, req_if.y_pos, req_if.char_code,
                   req_if.color, req_if.page_sel};
            sb.note_request(rq);
        end
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            rs = '{rsp_if.read_data, rsp_if.cursor_col, rsp_if.cursor_row};
            sb.check_response(rs);
        end
    end

    // Response side: random stalls, plus one long hold-off on request
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Timeout
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("mono_framebuffer_glyph_renderer_tb: done, errors");
        $finish;
    end

    initial begin
        sb          = new();
        tx_idle_pct = 33;
        rx_idle_pct = 33;
        hold_req    = 1'b0;
        req_if.valid     <= 1'b0;
        req_if.cmd       <= mfgr_pkg::CMD_SET_CURSOR;
        req_if.x_pos     <= 8'h00;
        req_if.y_pos     <= 8'h00;
        req_if.char_code <= 8'h00;
        req_if.color     <= 1'b0;
        req_if.page_sel  <= 3'd0;
        rst_n            <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: glyphs, wrap and clip of the cursor, pixel corners, reads, fills
        send(mfgr_pkg::CMD_READ_BYTE,  8'd0,   8'd0,   8'h00, 1'b0, 3'd0);
        send(mfgr_pkg::CMD_PUT_CHAR,   8'd0,   8'd0,   8'h24, 1'b1, 3'd0);
        send(mfgr_pkg::CMD_READ_BYTE,  8'd2,   8'd0,   8'h00, 1'b0, 3'd0);
        send(mfgr_pkg::CMD_SET_CURSOR, 8'd250, 8'd60,  8'h00, 1'b0, 3'd0);
        send(mfgr_pkg::CMD_PUT_CHAR,   8'd0,   8'd0,   8'h23, 1'b0, 3'd0);
        send(mfgr_pkg::CMD_PUT_CHAR,   8'd0,   8'd0,   8'h20, 1'b1, 3'd0);
        send(mfgr_pkg::CMD_SET_CURSOR, 8'd122, 8'd255, 8'h00, 1'b0, 3'd0);
        send(mfgr_pkg::CMD_PUT_CHAR,   8'd0,   8'd0,   8'h21, 1'b1, 3'd0);
        send(mfgr_pkg::CMD_PUT_CHAR,   8'd0,   8'd0,   8'h22, 1'b1, 3'd0);
        send(mfgr_pkg::CMD_PUT_CHAR,   8'd0,   8'd0,   8'h00, 1'b1, 3'd0);
        send(mfgr_pkg::CMD_PUT_CHAR,   8'd0,   8'd0,   8'hFF, 1'b0, 3'd0);
        send(mfgr_pkg::CMD_PUT_CHAR,   8'd0,   8'd0,   8'h25, 1'b1, 3'd0);
        send(mfgr_pkg::CMD_DRAW_PIXEL, 8'd127, 8'd63,  8'h00, 1'b1, 3'd0);
        send(mfgr_pkg::CMD_DRAW_PIXEL, 8'd128, 8'd0,   8'h00, 1'b1, 3'd0);
        send(mfgr_pkg::CMD_DRAW_PIXEL, 8'd0,   8'd64,  8'h00, 1'b1, 3'd0);
        send(mfgr_pkg::CMD_DRAW_PIXEL, 8'd255, 8'd255, 8'h00, 1'b1, 3'd0);
        send(mfgr_pkg::CMD_DRAW_PIXEL, 8'd0,   8'd0,   8'h00, 1'b0, 3'd0);
        send(mfgr_pkg::CMD_READ_BYTE,  8'd127, 8'd0,   8'h00, 1'b0, 3'd7);
        send(mfgr_pkg::CMD_READ_BYTE,  8'd128, 8'd0,   8'h00, 1'b0, 3'd0);
        send(mfgr_pkg::CMD_READ_BYTE,  8'd255, 8'd255, 8'hFF, 1'b1, 3'd7);
        send(CMD_RSVD_A,               8'd3,   8'd4,   8'h41, 1'b1, 3'd1);
        send(CMD_RSVD_B,               8'd200, 8'd9,   8'h24, 1'b0, 3'd5);
        send(CMD_RSVD_C,               8'd255, 8'd255, 8'hFF, 1'b1, 3'd7);
        send(mfgr_pkg::CMD_FILL,       8'd0,   8'd0,   8'h00, 1'b1, 3'd0);
        send(mfgr_pkg::CMD_READ_BYTE,  8'd64,  8'd0,   8'h00, 1'b0, 3'd3);
        send(mfgr_pkg::CMD_FILL,       8'd0,   8'd0,   8'h00, 1'b0, 3'd0);

        // Random part with phases: no idling, long response hold-off, full drain
        for (int k = 0; k < RANDOM_REQS; k++) begin
            if (k == 200) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (k == 330) begin
                tx_idle_pct = 33;
                rx_idle_pct = 33;
            end
            if (k == 380) begin
                tx_idle_pct = 0;
                hold_req    = 1'b1;
            end
            if (k == 420) tx_idle_pct = 33;
            if (k == 480) begin
                req_if.valid <= 1'b0;
                @(posedge clk);
                while (sb.pending() != 0) @(posedge clk);
            end
            send_random();
        end
        req_if.valid <= 1'b0;

        // Drain, then let any trailing work settle
        while (sb.pending() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0) $display("mono_framebuffer_glyph_renderer_tb: done, clean");
        else $display("mono_framebuffer_glyph_renderer_tb: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
design/mfgr_pkg.sv
design/mfgr_if.sv
design/mfgr_ram.sv
design/mfgr_fifo.sv
design/mfgr_front.sv
design/mfgr_back.sv
design/mono_framebuffer_glyph_renderer.sv
verif/mono_framebuffer_glyph_renderer_tb.sv
